// ===== design/cbts_pkg.sv =====
// Shared types and constants for the CAN bit timing solver.
// Used by cbts_div, can_bit_timing_solver_core and the testbench. No dependencies.
package cbts_pkg;

    // Field widths
    localparam int CLK_W     = 32;
    localparam int RATE_W    = 24;
    localparam int Q_W       = 5;
    localparam int PRESC_W   = 16;
    localparam int DIVISOR_W = RATE_W + Q_W;

    // Search of quanta counts, outward from the base count
    localparam int BASE_QUANTA = 16;
    localparam int SEARCH_SPAN = 9;
    localparam int OFF_W       = $clog2(SEARCH_SPAN + 2);
    localparam int CAND_W      = 8;
    localparam int Q_MIN       = 2;
    localparam int Q_MAX       = 31;

    // Divider steps, one quotient bit per step
    localparam int DIV_STEPS = CLK_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_DIV    = 2'd1,
        ST_ZERO_RATE = 2'd2,
        ST_OVERFLOW  = 2'd3
    } t_status;

    // Control towards the divider
    typedef struct packed {
        logic start;
    } t_div_ctrl;

    // Status back from the divider
    typedef struct packed {
        logic done;
        logic exact;
    } t_div_stat;

endpackage

// ===== design/cbts_div.sv =====
// Bit-serial restoring divider: one quotient bit per clock cycle.
// Depends on cbts_pkg.
module cbts_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  cbts_pkg::t_div_ctrl             i_ctrl,
    input  logic [cbts_pkg::CLK_W-1:0]      i_dividend,
    input  logic [cbts_pkg::DIVISOR_W-1:0]  i_divisor,
    output cbts_pkg::t_div_stat             o_stat,
    output logic [cbts_pkg::CLK_W-1:0]      o_quot
);
    import cbts_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [STEP_W-1:0]    r_cnt;
    logic [DIVISOR_W-1:0] r_rem;
    logic [CLK_W-1:0]     r_quo;

    logic [DIVISOR_W:0]   n_shift;
    logic [DIVISOR_W:0]   n_diff;
    logic                 n_bit;

    // Bring down the next dividend bit and try the subtraction
    always_comb begin
        n_shift = {r_rem, r_quo[CLK_W-1]};
        n_diff  = n_shift - {1'b0, i_divisor};
        n_bit   = (n_shift >= {1'b0, i_divisor});
    end

    // Shift dividend out and quotient in, one bit a cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctrl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_quo  <= i_dividend;
            end else if (r_busy) begin
                r_rem <= n_bit ? n_diff[DIVISOR_W-1:0] : n_shift[DIVISOR_W-1:0];
                r_quo <= {r_quo[CLK_W-2:0], n_bit};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == STEP_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_stat.done  = r_done;
    assign o_stat.exact = (r_rem == '0);
    assign o_quot       = r_quo;

endmodule

// ===== design/can_bit_timing_solver_core.sv =====
// CAN nominal bit timing solver, top level.
// Depends on cbts_pkg and cbts_div.
//
// Pulse start while busy is low to hand in a kernel clock and a bitrate. The
// block tries quanta counts 16, 16, 15, 17, 14, 18 ... 7, 25 in turn; each
// trial divides the clock by bitrate times count on a shared bit-serial
// divider, so an item ends far sooner when an early count divides than when
// no count fits. A zero bitrate is answered in the cycle straight after
// start, and busy never rises for it. The result appears for exactly one
// cycle with o_valid high and must be captured then; the receiver cannot
// hold it off. Busy stays high until that cycle.
module can_bit_timing_solver_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [cbts_pkg::CLK_W-1:0]      i_clock_hz,
    input  logic [cbts_pkg::RATE_W-1:0]     i_target_bitrate,
    output logic                            o_valid,
    output logic [1:0]                      o_status,
    output logic [cbts_pkg::PRESC_W-1:0]    o_prescaler,
    output logic [cbts_pkg::Q_W-1:0]        o_quanta_per_bit,
    output logic [cbts_pkg::Q_W-1:0]        o_phase_seg1,
    output logic [cbts_pkg::Q_W-1:0]        o_phase_seg2
);
    import cbts_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CAND,
        S_KICK,
        S_WAIT,
        S_NEXT,
        S_FIN
    } t_state;

    t_state                r_state;
    logic [CLK_W-1:0]      r_clk;
    logic [RATE_W-1:0]     r_rate;
    logic [OFF_W-1:0]      r_off;
    logic                  r_side;
    logic [Q_W-1:0]        r_q;
    logic [DIVISOR_W-1:0]  r_divisor;

    logic                  r_valid;
    t_status               r_status;
    logic [PRESC_W-1:0]    r_presc;
    logic [Q_W-1:0]        r_qpb;
    logic [Q_W-1:0]        r_seg1;
    logic [Q_W-1:0]        r_seg2;

    logic signed [CAND_W-1:0] n_cand;
    logic                     n_cand_ok;
    logic [DIVISOR_W-1:0]     n_divisor;
    logic [Q_W+2:0]           n_seven_q;
    logic [Q_W-1:0]           n_a;
    logic [Q_W-1:0]           n_seg1;
    logic [Q_W-1:0]           n_seg2;

    t_div_ctrl            div_ctrl;
    t_div_stat            div_stat;
    logic [CLK_W-1:0]     div_quot;

    // Candidate count for the current offset and side
    always_comb begin
        if (r_side) begin
            n_cand = CAND_W'(BASE_QUANTA) + $signed(CAND_W'(r_off));
        end else begin
            n_cand = CAND_W'(BASE_QUANTA) - $signed(CAND_W'(r_off));
        end
        n_cand_ok = (n_cand >= CAND_W'(Q_MIN)) && (n_cand <= CAND_W'(Q_MAX));
        n_divisor = DIVISOR_W'(r_rate) * DIVISOR_W'(n_cand[Q_W-1:0]);
    end

    // Sample point (one plus segment 1) nearest seven eighths; a tie keeps the lower value
    always_comb begin
        n_seven_q = {r_q, 3'b000} - (Q_W+3)'(r_q);
        n_a       = n_seven_q[Q_W+2:3];
        n_seg1    = (n_seven_q[2:0] > 3'd4) ? n_a : n_a - 1'b1;
        n_seg2    = r_q - n_seg1 - 1'b1;
    end

    assign div_ctrl.start = (r_state == S_KICK);

    cbts_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (div_ctrl),
        .i_dividend (r_clk),
        .i_divisor  (r_divisor),
        .o_stat     (div_stat),
        .o_quot     (div_quot)
    );

    // Sequence the search and register the result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_clk  <= i_clock_hz;
                        r_rate <= i_target_bitrate;
                        r_off  <= '0;
                        r_side <= 1'b0;
                        if (i_target_bitrate == '0) begin
                            r_valid  <= 1'b1;
                            r_status <= ST_ZERO_RATE;
                            r_presc  <= '0;
                            r_qpb    <= '0;
                            r_seg1   <= '0;
                            r_seg2   <= '0;
                        end else begin
                            r_state <= S_CAND;
                        end
                    end
                end
                S_CAND: begin
                    // skip counts out of range without a trial
                    if (n_cand_ok) begin
                        r_q       <= n_cand[Q_W-1:0];
                        r_divisor <= n_divisor;
                        r_state   <= S_KICK;
                    end else begin
                        r_state <= S_NEXT;
                    end
                end
                S_KICK: begin
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (div_stat.done) begin
                        r_state <= div_stat.exact ? S_FIN : S_NEXT;
                    end
                end
                S_NEXT: begin
                    if (!r_side) begin
                        r_side  <= 1'b1;
                        r_state <= S_CAND;
                    end else if (r_off == OFF_W'(SEARCH_SPAN)) begin
                        r_valid  <= 1'b1;
                        r_status <= ST_NO_DIV;
                        r_presc  <= '0;
                        r_qpb    <= '0;
                        r_seg1   <= '0;
                        r_seg2   <= '0;
                        r_state  <= S_IDLE;
                    end else begin
                        r_off   <= r_off + 1'b1;
                        r_side  <= 1'b0;
                        r_state <= S_CAND;
                    end
                end
                S_FIN: begin
                    r_valid <= 1'b1;
                    r_state <= S_IDLE;
                    if (div_quot[CLK_W-1:PRESC_W] != '0) begin
                        r_status <= ST_OVERFLOW;
                        r_presc  <= '0;
                        r_qpb    <= '0;
                        r_seg1   <= '0;
                        r_seg2   <= '0;
                    end else begin
                        r_status <= ST_OK;
                        r_presc  <= div_quot[PRESC_W-1:0];
                        r_qpb    <= r_q;
                        r_seg1   <= n_seg1;
                        r_seg2   <= n_seg2;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy             = (r_state != S_IDLE);
    assign o_valid          = r_valid;
    assign o_status         = r_status;
    assign o_prescaler      = r_presc;
    assign o_quanta_per_bit = r_qpb;
    assign o_phase_seg1     = r_seg1;
    assign o_phase_seg2     = r_seg2;

endmodule

// ===== tb/sv/tb_can_bit_timing_solver_core.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for can_bit_timing_solver_core: clocked driver and monitor,
// with a built-in predictor of the quanta search and the segment split.
// Depends on cbts_pkg and the solver RTL.
module tb_can_bit_timing_solver_core;
    import cbts_pkg::*;

    localparam int QUIET_LIMIT = 5000;
    localparam int SETTLE_CYCLES = 800;

    typedef struct {
        logic [CLK_W-1:0]  clk_hz;
        logic [RATE_W-1:0] rate;
        bit                drain_first;
    } t_item;

    typedef struct {
        t_status              status;
        logic [PRESC_W-1:0]   presc;
        logic [Q_W-1:0]       quanta;
        logic [Q_W-1:0]       seg1;
        logic [Q_W-1:0]       seg2;
    } t_timing;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                start = 1'b0;
    logic [CLK_W-1:0]    i_clock_hz = '0;
    logic [RATE_W-1:0]   i_target_bitrate = '0;
    logic                busy;
    logic                o_valid;
    logic [1:0]          o_status;
    logic [PRESC_W-1:0]  o_prescaler;
    logic [Q_W-1:0]      o_quanta_per_bit;
    logic [Q_W-1:0]      o_phase_seg1;
    logic [Q_W-1:0]      o_phase_seg2;

    t_item   stimulus[$];
    t_timing timing_due[$];
    int      mismatches = 0;
    int      in_flight = 0;
    int      quiet_cycles = 0;
    int      sent_items = 0;

    can_bit_timing_solver_core DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_clock_hz       (i_clock_hz),
        .i_target_bitrate (i_target_bitrate),
        .o_valid          (o_valid),
        .o_status         (o_status),
        .o_prescaler      (o_prescaler),
        .o_quanta_per_bit (o_quanta_per_bit),
        .o_phase_seg1     (o_phase_seg1),
        .o_phase_seg2     (o_phase_seg2)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Search counts outward from the base, then split the bit round the 7/8 sample point
    function automatic t_timing solve_bit_timing(logic [CLK_W-1:0] clk_hz,
                                                 logic [RATE_W-1:0] rate);
        t_timing         res;
        longint unsigned clk64;
        longint unsigned rate64;
        longint unsigned presc;
        int              cand;
        int              q;
        int              below;
        int              miss;
        clk64 = clk_hz;
        rate64 = rate;
        res.status = ST_OK;
        res.presc = '0;
        res.quanta = '0;
        res.seg1 = '0;
        res.seg2 = '0;
        if (rate64 == 0) begin
            res.status = ST_ZERO_RATE;
            return res;
        end
        q = 0;
        for (int off = 0; off <= SEARCH_SPAN && q == 0; off++) begin
            for (int side = 0; side < 2 && q == 0; side++) begin
                cand = (side == 0) ? BASE_QUANTA - off : BASE_QUANTA + off;
                if (cand >= Q_MIN && cand <= Q_MAX
                    && clk64 % (rate64 * longint'(cand)) == 0)
                    q = cand;
            end
        end
        if (q == 0) begin
            res.status = ST_NO_DIV;
            return res;
        end
        presc = clk64 / (rate64 * longint'(q));
        if (presc > 64'hFFFF) begin
            res.status = ST_OVERFLOW;
            return res;
        end
        // below/q is the sample point at or just under 7/8; miss is its shortfall in eighths
        below = (7 * q) / 8;
        miss = 7 * q - 8 * below;
        res.presc = presc[PRESC_W-1:0];
        res.quanta = q[Q_W-1:0];
        res.seg1 = (miss > 4) ? below[Q_W-1:0] : below[Q_W-1:0] - 1'b1;
        res.seg2 = q[Q_W-1:0] - res.seg1 - 1'b1;
        return res;
    endfunction

    // Build clock = rate * quanta * prescaler with a random rate that still fits 32 bits
    function automatic t_item shaped_item(int unsigned presc_lo, int unsigned presc_hi);
        t_item           it;
        longint unsigned span;
        longint unsigned rate_max;
        int unsigned     q;
        int unsigned     presc;
        int unsigned     pick;
        int unsigned     bitrates[9] = '{10000, 20000, 50000, 100000, 125000,
                                         250000, 500000, 800000, 1000000};
        q = $urandom_range(BASE_QUANTA + SEARCH_SPAN, BASE_QUANTA - SEARCH_SPAN);
        presc = $urandom_range(presc_hi, presc_lo);
        span = longint'(q) * presc;
        rate_max = 64'hFFFF_FFFF / span;
        if (rate_max > 64'hFF_FFFF)
            rate_max = 64'hFF_FFFF;
        if (rate_max == 0)
            rate_max = 1;
        it.rate = RATE_W'($urandom_range(int'(rate_max), 1));
        // now and then take a common bitrate when it fits
        pick = $urandom_range(8);
        if ($urandom_range(1) == 1 && bitrates[pick] <= rate_max)
            it.rate = RATE_W'(bitrates[pick]);
        it.clk_hz = CLK_W'(longint'(it.rate) * span);
        it.drain_first = 1'b0;
        return it;
    endfunction

    function automatic t_item plain_item(logic [CLK_W-1:0] clk_hz, logic [RATE_W-1:0] rate);
        t_item it;
        it.clk_hz = clk_hz;
        it.rate = rate;
        it.drain_first = 1'b0;
        return it;
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, name, want, got);
        end
    endtask

    // Offer the head of the queue; hold start until busy lets the item through
    always @(posedge i_clk) begin
        bit taken;
        bit gap;
        bit blocked;
        taken = start && !busy;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (taken) begin
                void'(stimulus.pop_front());
                sent_items++;
            end
            if (!start || taken) begin
                gap = (sent_items >= 200 && sent_items < 320) ? 1'b0
                                                              : ($urandom_range(99) < 22);
                blocked = stimulus.size() != 0 && stimulus[0].drain_first
                          && (taken || in_flight != 0 || busy);
                if (stimulus.size() != 0 && !gap && !blocked) begin
                    start <= 1'b1;
                    i_clock_hz <= stimulus[0].clk_hz;
                    i_target_bitrate <= stimulus[0].rate;
                end else begin
                    start <= 1'b0;
                    i_clock_hz <= $urandom;
                    i_target_bitrate <= RATE_W'($urandom);
                end
            end
        end
    end

    // Check each result strobe against the oldest prediction, then log new items
    always @(posedge i_clk) begin
        t_timing want;
        bit      accepted;
        bit      strobe;
        accepted = start && !busy;
        strobe = (o_valid === 1'b1);
        if (i_rst_n) begin
            if (strobe) begin
                if (timing_due.size() == 0) begin
                    mismatches++;
                    $display("%0t: result with nothing expected, expected none, actual status %0d",
                             $realtime, o_status);
                end else begin
                    want = timing_due.pop_front();
                    check_field("status", want.status, o_status);
                    check_field("prescaler", want.presc, o_prescaler);
                    check_field("quanta_per_bit", want.quanta, o_quanta_per_bit);
                    check_field("phase_seg1", want.seg1, o_phase_seg1);
                    check_field("phase_seg2", want.seg2, o_phase_seg2);
                end
            end
            if (accepted)
                timing_due.push_back(solve_bit_timing(i_clock_hz, i_target_bitrate));
            in_flight <= in_flight + int'(accepted) - int'(strobe);
            quiet_cycles <= (accepted || strobe) ? 0 : quiet_cycles + 1;
        end
    end

    // Stop a hung run
    initial begin
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge i_clk);
        $display("status: fail");
        $finish;
    end

    initial begin
        t_item it;
        int    pick;

        // Directed: zero clock, zero bitrate, field extremes, prescaler edge, each count
        stimulus.push_back(plain_item(32'd0, 24'd1));
        stimulus.push_back(plain_item($urandom, 24'd0));
        stimulus.push_back(plain_item(32'hFFFF_FFFF, 24'hFF_FFFF));
        stimulus.push_back(plain_item(32'hFFFF_FFFF, 24'd1));
        stimulus.push_back(plain_item(32'd16 * 32'd65535, 24'd1));
        stimulus.push_back(plain_item(32'd16 * 32'd65536, 24'd1));
        for (int q = BASE_QUANTA - SEARCH_SPAN; q <= BASE_QUANTA + SEARCH_SPAN; q++)
            stimulus.push_back(plain_item(CLK_W'(q * 1009), 24'd1));

        // Random: mostly exact products, with overflow, zero bitrate and raw noise
        for (int n = 0; n < 475; n++) begin
            pick = $urandom_range(99);
            if (pick < 40)
                it = shaped_item(1, 40);
            else if (pick < 55)
                it = shaped_item(1, 4000);
            else if (pick < 62)
                it = shaped_item(4000, 65535);
            else if (pick < 72)
                it = shaped_item(65536, 400000);
            else if (pick < 80)
                it = plain_item($urandom, 24'd0);
            else if (pick < 90)
                it = plain_item($urandom, RATE_W'($urandom));
            else
                it = plain_item($urandom, RATE_W'($urandom_range(2000, 1)));
            it.drain_first = (n == 100 || n == 330);
            stimulus.push_back(it);
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Drain, then give a stray strobe time to show up
        while (stimulus.size() != 0 || start)
            @(posedge i_clk);
        while (timing_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (timing_due.size() != 0)
            mismatches++;

        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== can_bit_timing_solver_core.f =====
design/cbts_pkg.sv
design/cbts_div.sv
design/can_bit_timing_solver_core.sv
tb/sv/tb_can_bit_timing_solver_core.sv
